// File: rtl/i2cbe_pkg.sv
package i2cbe_pkg;

	localparam int unsigned ACK_COUNT_BITS_DEF = 16;

	localparam int unsigned SPEED_W   = 3;
	localparam int unsigned TMO_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned HALF_W    = 4;

	localparam logic [CFG_IDX_W-1:0] REG_SPEED_SELECT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LSB_FIRST    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT  = 2'd2;

	localparam logic [SPEED_W-1:0] SPEED_RESET   = 3'd2;
	localparam logic               LSB_RESET     = 1'b0;
	localparam logic [TMO_W-1:0]   TIMEOUT_RESET = 16'd1000;

	localparam logic [2:0] FN_TICK    = 3'd0;
	localparam logic [2:0] FN_START   = 3'd1;
	localparam logic [2:0] FN_STOP    = 3'd2;
	localparam logic [2:0] FN_WRITE   = 3'd3;
	localparam logic [2:0] FN_RD_ACK  = 3'd4;
	localparam logic [2:0] FN_RD_NACK = 3'd5;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TIMEOUT = 2'd1,
		ST_REJECT  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_ST1    = 4'd1,
		PH_ST2    = 4'd2,
		PH_SP1    = 4'd3,
		PH_SP2    = 4'd4,
		PH_WSETUP = 4'd5,
		PH_WHIGH  = 4'd6,
		PH_WLOW   = 4'd7,
		PH_AREL   = 4'd8,
		PH_AHIGH  = 4'd9,
		PH_APOLL  = 4'd10,
		PH_RLOW   = 4'd11,
		PH_RHIGH  = 4'd12,
		PH_K1     = 4'd13,
		PH_K2     = 4'd14
	} phase_t;

	typedef struct packed {
		phase_t            phase;
		logic [2:0]        pending_op;
		logic [3:0]        bit_index;
		logic [7:0]        shift_byte;
		logic [HALF_W-1:0] half_cnt;
		logic              scl;
		logic              sda;
		logic              sda_drv;
		logic [7:0]        rd_hold;
	} eng_state_t;

	typedef struct packed {
		logic [SPEED_W-1:0] speed_select;
		logic               lsb_first;
		logic [TMO_W-1:0]   ack_timeout;
	} eng_cfg_t;

	function automatic logic [HALF_W-1:0] half_ticks(input logic [SPEED_W-1:0] sel);
		logic [HALF_W-1:0] d;
		unique case (sel)
			3'd0: d = 4'd10;
			3'd1: d = 4'd5;
			3'd3: d = 4'd2;
			3'd4: d = 4'd1;
			default: d = 4'd4;
		endcase
		return d;
	endfunction

	// Returns the next bit to drive on SDA in bit 8 and the shifted byte below it.
	function automatic logic [8:0] put_bit(input logic [7:0] sh, input logic lsb);
		logic [8:0] r;
		if (lsb) begin
			r = {sh[0], 1'b0, sh[7:1]};
		end else begin
			r = {sh[7], sh[6:0], 1'b0};
		end
		return r;
	endfunction

endpackage

// File: rtl/i2c_master_bit_engine_core.sv
// I2C master bit engine. Each input item is either a microsecond tick or a command
// (start, stop, write byte with ack check, read byte with ack or nack), together with
// the sampled SDA level. The engine takes one item per clock and returns exactly one
// result item for it, registered, on the following cycle: the SCL and SDA levels, the
// SDA drive enable, busy, done, status and the last read byte. A new item is taken
// in the same cycle a pending result is taken, so the sustained rate is one item per
// clock, set by the single state update between the engine registers. Half periods
// last 10, 5, 4, 2 or 1 ticks as chosen by speed_select; a command given while busy
// is rejected with status 2, and an ack timeout issues one stop and reports status 1.
module i2c_master_bit_engine_core
	import i2cbe_pkg::*;
#(
	parameter int unsigned ACK_COUNT_BITS = ACK_COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           func,
	input  logic [7:0]           wr_byte,
	input  logic                 sda_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 scl_out,
	output logic                 sda_out,
	output logic                 sda_drive,
	output logic                 busy_res,
	output logic                 done_res,
	output logic [1:0]           status,
	output logic [7:0]           rd_byte
);

	eng_cfg_t                  cfg_q;
	eng_state_t                state_q;
	eng_state_t                state_nxt;
	logic [ACK_COUNT_BITS-1:0] ack_cnt_q;
	logic [ACK_COUNT_BITS-1:0] ack_cnt_nxt;
	logic                      done_nxt;
	status_t                   status_nxt;
	logic                      out_valid_q;
	logic                      done_q;
	status_t                   status_q;
	logic                      accept;

	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_select <= SPEED_RESET;
			cfg_q.lsb_first <= LSB_RESET;
			cfg_q.ack_timeout <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SPEED_SELECT: cfg_q.speed_select <= cfg_wdata[SPEED_W-1:0];
				REG_LSB_FIRST: cfg_q.lsb_first <= cfg_wdata[0];
				REG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_wdata[TMO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	i2cbe_step #(
		.ACK_COUNT_BITS(ACK_COUNT_BITS)
	) u_step (
		.cur        (state_q),
		.ack_cnt    (ack_cnt_q),
		.cfg        (cfg_q),
		.func       (func),
		.wr_byte    (wr_byte),
		.sda_in     (sda_in),
		.nxt        (state_nxt),
		.ack_cnt_nxt(ack_cnt_nxt),
		.done       (done_nxt),
		.status     (status_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= PH_IDLE;
			state_q.pending_op <= 3'd0;
			state_q.bit_index <= 4'd0;
			state_q.shift_byte <= 8'd0;
			state_q.half_cnt <= '0;
			state_q.scl <= 1'b1;
			state_q.sda <= 1'b1;
			state_q.sda_drv <= 1'b1;
			state_q.rd_hold <= 8'd0;
			ack_cnt_q <= '0;
			out_valid_q <= 1'b0;
			done_q <= 1'b0;
			status_q <= ST_OK;
		end else begin
			if (accept) begin
				state_q <= state_nxt;
				ack_cnt_q <= ack_cnt_nxt;
				done_q <= done_nxt;
				status_q <= status_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The engine state changes only when an item is taken, so it also holds the
	// pin levels of the result that is waiting.
	assign out_valid = out_valid_q;
	assign scl_out = state_q.scl;
	assign sda_out = state_q.sda;
	assign sda_drive = state_q.sda_drv;
	assign busy_res = (state_q.phase != PH_IDLE);
	assign done_res = done_q;
	assign status = status_q;
	assign rd_byte = state_q.rd_hold;

endmodule

// File: rtl/i2cbe_step.sv
module i2cbe_step
	import i2cbe_pkg::*;
#(
	parameter int unsigned ACK_COUNT_BITS = ACK_COUNT_BITS_DEF
) (
	input  eng_state_t                cur,
	input  logic [ACK_COUNT_BITS-1:0] ack_cnt,
	input  eng_cfg_t                  cfg,
	input  logic [2:0]                func,
	input  logic [7:0]                wr_byte,
	input  logic                      sda_in,
	output eng_state_t                nxt,
	output logic [ACK_COUNT_BITS-1:0] ack_cnt_nxt,
	output logic                      done,
	output status_t                   status
);

	localparam int unsigned CW = (ACK_COUNT_BITS > TMO_W) ? ACK_COUNT_BITS : TMO_W;
	localparam logic [ACK_COUNT_BITS-1:0] ACK_MAX = {ACK_COUNT_BITS{1'b1}};
	localparam logic [ACK_COUNT_BITS-1:0] ACK_ONE = ACK_COUNT_BITS'(1);

	logic                      is_cmd;
	logic                      do_poll;
	logic [HALF_W-1:0]         dticks;
	logic [8:0]                pb;
	logic [3:0]                bi_inc;
	logic [ACK_COUNT_BITS-1:0] poll_base;
	logic [ACK_COUNT_BITS-1:0] poll_inc;

	assign dticks = half_ticks(cfg.speed_select);
	assign bi_inc = cur.bit_index + 4'd1;
	assign is_cmd = (func == FN_START) || (func == FN_STOP) || (func == FN_WRITE) ||
		(func == FN_RD_ACK) || (func == FN_RD_NACK);
	assign poll_base = (cur.phase == PH_AHIGH) ? '0 : ack_cnt;
	assign poll_inc = (poll_base != ACK_MAX) ? poll_base + ACK_ONE : poll_base;

	always_comb begin
		nxt = cur;
		ack_cnt_nxt = ack_cnt;
		done = 1'b0;
		status = ST_OK;
		do_poll = 1'b0;
		pb = put_bit(wr_byte, cfg.lsb_first);
		if (is_cmd && (cur.phase != PH_IDLE)) begin
			done = 1'b1;
			status = ST_REJECT;
		end else if (is_cmd) begin
			nxt.pending_op = func;
			nxt.bit_index = 4'd0;
			nxt.half_cnt = dticks;
			if (func == FN_START) begin
				nxt.sda_drv = 1'b1;
				nxt.sda = 1'b1;
				nxt.scl = 1'b1;
				nxt.phase = PH_ST1;
			end else if (func == FN_STOP) begin
				nxt.sda_drv = 1'b1;
				nxt.scl = 1'b0;
				nxt.sda = 1'b0;
				nxt.phase = PH_SP1;
			end else if (func == FN_WRITE) begin
				nxt.sda_drv = 1'b1;
				nxt.scl = 1'b0;
				nxt.sda = pb[8];
				nxt.shift_byte = pb[7:0];
				nxt.phase = PH_WSETUP;
			end else begin
				nxt.sda_drv = 1'b0;
				nxt.sda = 1'b1;
				nxt.scl = 1'b0;
				nxt.shift_byte = 8'd0;
				nxt.phase = PH_RLOW;
			end
		end else if (cur.phase == PH_APOLL) begin
			do_poll = 1'b1;
		end else if (cur.phase != PH_IDLE) begin
			if (cur.half_cnt <= 4'd1) begin
				nxt.half_cnt = '0;
				pb = put_bit(cur.shift_byte, cfg.lsb_first);
				unique case (cur.phase)
					PH_ST1: begin
						nxt.sda = 1'b0;
						nxt.phase = PH_ST2;
						nxt.half_cnt = dticks;
					end
					PH_ST2: begin
						nxt.scl = 1'b0;
						nxt.phase = PH_IDLE;
						done = 1'b1;
					end
					PH_SP1: begin
						nxt.scl = 1'b1;
						nxt.sda = 1'b1;
						nxt.phase = PH_SP2;
						nxt.half_cnt = dticks;
					end
					PH_SP2: begin
						nxt.phase = PH_IDLE;
						done = 1'b1;
						status = (cur.pending_op == FN_WRITE) ? ST_TIMEOUT : ST_OK;
					end
					PH_WSETUP: begin
						nxt.scl = 1'b1;
						nxt.phase = PH_WHIGH;
						nxt.half_cnt = dticks;
					end
					PH_WHIGH: begin
						nxt.scl = 1'b0;
						nxt.phase = PH_WLOW;
						nxt.half_cnt = dticks;
					end
					PH_WLOW: begin
						nxt.bit_index = bi_inc;
						nxt.half_cnt = dticks;
						if (!bi_inc[3]) begin
							nxt.sda = pb[8];
							nxt.shift_byte = pb[7:0];
							nxt.phase = PH_WSETUP;
						end else begin
							nxt.sda_drv = 1'b0;
							nxt.sda = 1'b1;
							nxt.phase = PH_AREL;
						end
					end
					PH_AREL: begin
						nxt.scl = 1'b1;
						nxt.phase = PH_AHIGH;
						nxt.half_cnt = dticks;
					end
					PH_AHIGH: begin
						do_poll = 1'b1;
					end
					PH_RLOW: begin
						nxt.scl = 1'b1;
						nxt.shift_byte = cfg.lsb_first ? {sda_in, cur.shift_byte[7:1]} :
							{cur.shift_byte[6:0], sda_in};
						nxt.phase = PH_RHIGH;
						nxt.half_cnt = dticks;
					end
					PH_RHIGH: begin
						nxt.bit_index = bi_inc;
						nxt.scl = 1'b0;
						nxt.half_cnt = dticks;
						if (!bi_inc[3]) begin
							nxt.phase = PH_RLOW;
						end else begin
							nxt.rd_hold = cur.shift_byte;
							nxt.sda_drv = 1'b1;
							nxt.sda = (cur.pending_op == FN_RD_NACK);
							nxt.phase = PH_K1;
						end
					end
					PH_K1: begin
						nxt.scl = 1'b1;
						nxt.phase = PH_K2;
						nxt.half_cnt = dticks;
					end
					PH_K2: begin
						nxt.scl = 1'b0;
						nxt.phase = PH_IDLE;
						done = 1'b1;
					end
					default: begin
						nxt.phase = PH_IDLE;
					end
				endcase
			end else begin
				nxt.half_cnt = cur.half_cnt - 4'd1;
			end
		end

		if (do_poll) begin
			if (!sda_in) begin
				ack_cnt_nxt = poll_base;
				nxt.scl = 1'b0;
				nxt.phase = PH_IDLE;
				done = 1'b1;
				status = ST_OK;
			end else begin
				ack_cnt_nxt = poll_inc;
				if ((CW'(poll_inc) >= CW'(cfg.ack_timeout)) || (poll_inc == ACK_MAX)) begin
					nxt.sda_drv = 1'b1;
					nxt.scl = 1'b0;
					nxt.sda = 1'b0;
					nxt.phase = PH_SP1;
					nxt.half_cnt = dticks;
				end else begin
					nxt.phase = PH_APOLL;
				end
			end
		end
	end

endmodule

// File: bench/i2c_master_bit_engine_core_tb.sv
module i2c_master_bit_engine_core_tb;
	import i2cbe_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] FN_SPARE_LO = 3'd6;
	localparam logic [2:0] FN_SPARE_HI = 3'd7;
	localparam int unsigned ACK_MAX = (1 << ACK_COUNT_BITS_DEF) - 1;

	typedef enum int {HP_NONE, HP_OK, HP_TMO} hp_end_t;

	typedef struct packed {
		logic [2:0] fn;
		logic [7:0] wr;
		logic       sda;
	} cmd_item_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       drv;
		logic       busy;
		logic       done;
		status_t    st;
		logic [7:0] rd;
	} bus_view_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [2:0]           func = FN_TICK;
	logic [7:0]           wr_byte = 8'h00;
	logic                 sda_in = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 scl_out;
	logic                 sda_out;
	logic                 sda_drive;
	logic                 busy_res;
	logic                 done_res;
	logic [1:0]           status;
	logic [7:0]           rd_byte;

	// Engine state as the predictor tracks it.
	phase_t       eng_phase = PH_IDLE;
	logic [2:0]   eng_op = 3'd0;
	logic [3:0]   eng_bit = 4'd0;
	logic [7:0]   eng_shift = 8'h00;
	logic [3:0]   eng_half = 4'd0;
	int unsigned  eng_ackcnt = 0;
	logic         eng_scl = 1'b1;
	logic         eng_sda = 1'b1;
	logic         eng_drv = 1'b1;
	logic [7:0]   eng_rd = 8'h00;

	logic [SPEED_W-1:0] sel_speed = SPEED_RESET;
	logic               sel_lsb = LSB_RESET;
	logic [TMO_W-1:0]   sel_tmo = TIMEOUT_RESET;

	cmd_item_t cmd_q[$];
	bus_view_t bus_expect_q[$];
	cmd_item_t next_cmd;
	bus_view_t seen_view;
	bus_view_t want_view;

	int  pushed_cnt = 0;
	int  taken_cnt = 0;
	int  bad_cnt = 0;
	bit  took = 1'b0;
	bit  src_calm = 1'b0;
	bit  snk_calm = 1'b0;
	bit  sink_hold = 1'b0;
	bit  squeeze_go = 1'b0;

	i2c_master_bit_engine_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.wr_byte   (wr_byte),
		.sda_in    (sda_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.scl_out   (scl_out),
		.sda_out   (sda_out),
		.sda_drive (sda_drive),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.status    (status),
		.rd_byte   (rd_byte)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int half_len(logic [SPEED_W-1:0] sel);
		case (sel)
			3'd0: return 10;
			3'd1: return 5;
			3'd3: return 2;
			3'd4: return 1;
			default: return 4;
		endcase
	endfunction

	function automatic void arm(phase_t nxt);
		eng_phase = nxt;
		eng_half = 4'(half_len(sel_speed));
	endfunction

	function automatic void shift_out();
		if (sel_lsb) begin
			eng_sda = eng_shift[0];
			eng_shift = eng_shift >> 1;
		end else begin
			eng_sda = eng_shift[7];
			eng_shift = eng_shift << 1;
		end
	endfunction

	function automatic hp_end_t poll_ack(logic sda);
		if (!sda) begin
			eng_scl = 1'b0;
			eng_phase = PH_IDLE;
			return HP_OK;
		end
		if (eng_ackcnt < ACK_MAX)
			eng_ackcnt++;
		if (eng_ackcnt >= sel_tmo || eng_ackcnt >= ACK_MAX) begin
			eng_drv = 1'b1;
			eng_scl = 1'b0;
			eng_sda = 1'b0;
			arm(PH_SP1);
		end else begin
			eng_phase = PH_APOLL;
		end
		return HP_NONE;
	endfunction

	function automatic hp_end_t half_done(logic sda);
		hp_end_t r;
		r = HP_NONE;
		case (eng_phase)
			PH_ST1: begin
				eng_sda = 1'b0;
				arm(PH_ST2);
			end
			PH_ST2: begin
				eng_scl = 1'b0;
				eng_phase = PH_IDLE;
				r = HP_OK;
			end
			PH_SP1: begin
				eng_scl = 1'b1;
				eng_sda = 1'b1;
				arm(PH_SP2);
			end
			PH_SP2: begin
				eng_phase = PH_IDLE;
				r = (eng_op == FN_WRITE) ? HP_TMO : HP_OK;
			end
			PH_WSETUP: begin
				eng_scl = 1'b1;
				arm(PH_WHIGH);
			end
			PH_WHIGH: begin
				eng_scl = 1'b0;
				arm(PH_WLOW);
			end
			PH_WLOW: begin
				eng_bit = eng_bit + 4'd1;
				if (eng_bit < 4'd8) begin
					shift_out();
					arm(PH_WSETUP);
				end else begin
					eng_drv = 1'b0;
					eng_sda = 1'b1;
					arm(PH_AREL);
				end
			end
			PH_AREL: begin
				eng_scl = 1'b1;
				arm(PH_AHIGH);
			end
			PH_AHIGH: begin
				eng_ackcnt = 0;
				r = poll_ack(sda);
			end
			PH_RLOW: begin
				eng_scl = 1'b1;
				if (sel_lsb)
					eng_shift = {sda, eng_shift[7:1]};
				else
					eng_shift = {eng_shift[6:0], sda};
				arm(PH_RHIGH);
			end
			PH_RHIGH: begin
				eng_bit = eng_bit + 4'd1;
				eng_scl = 1'b0;
				if (eng_bit < 4'd8) begin
					arm(PH_RLOW);
				end else begin
					eng_rd = eng_shift;
					eng_drv = 1'b1;
					eng_sda = (eng_op == FN_RD_NACK);
					arm(PH_K1);
				end
			end
			PH_K1: begin
				eng_scl = 1'b1;
				arm(PH_K2);
			end
			PH_K2: begin
				eng_scl = 1'b0;
				eng_phase = PH_IDLE;
				r = HP_OK;
			end
			default: eng_phase = PH_IDLE;
		endcase
		return r;
	endfunction

	function automatic bus_view_t engine_step(logic [2:0] fn, logic [7:0] wr, logic sda);
		bus_view_t v;
		hp_end_t   e;
		logic      is_cmd;
		v.done = 1'b0;
		v.st = ST_OK;
		is_cmd = (fn >= FN_START && fn <= FN_RD_NACK);
		if (is_cmd && eng_phase != PH_IDLE) begin
			v.done = 1'b1;
			v.st = ST_REJECT;
		end else if (is_cmd) begin
			eng_op = fn;
			eng_bit = 4'd0;
			case (fn)
				FN_START: begin
					eng_drv = 1'b1;
					eng_sda = 1'b1;
					eng_scl = 1'b1;
					arm(PH_ST1);
				end
				FN_STOP: begin
					eng_drv = 1'b1;
					eng_scl = 1'b0;
					eng_sda = 1'b0;
					arm(PH_SP1);
				end
				FN_WRITE: begin
					eng_drv = 1'b1;
					eng_scl = 1'b0;
					eng_shift = wr;
					shift_out();
					arm(PH_WSETUP);
				end
				default: begin
					eng_drv = 1'b0;
					eng_sda = 1'b1;
					eng_scl = 1'b0;
					eng_shift = 8'h00;
					arm(PH_RLOW);
				end
			endcase
		end else if (eng_phase == PH_APOLL) begin
			if (poll_ack(sda) == HP_OK)
				v.done = 1'b1;
		end else if (eng_phase != PH_IDLE) begin
			if (eng_half <= 4'd1) begin
				eng_half = 4'd0;
				e = half_done(sda);
				if (e != HP_NONE) begin
					v.done = 1'b1;
					v.st = (e == HP_TMO) ? ST_TIMEOUT : ST_OK;
				end
			end else begin
				eng_half = eng_half - 4'd1;
			end
		end
		v.scl = eng_scl;
		v.sda = eng_sda;
		v.drv = eng_drv;
		v.busy = (eng_phase != PH_IDLE);
		v.rd = eng_rd;
		return v;
	endfunction

	function automatic string view_str(bus_view_t v);
		return $sformatf("scl=%b sda=%b drv=%b busy=%b done=%b status=%0d rd=%h",
			v.scl, v.sda, v.drv, v.busy, v.done, v.st, v.rd);
	endfunction

	function automatic int tmo_polls();
		return (sel_tmo == 0) ? 1 : int'(sel_tmo);
	endfunction

	task automatic queue_item(logic [2:0] fn, logic [7:0] wr, logic sda);
		cmd_q.push_back('{fn: fn, wr: wr, sda: sda});
		pushed_cnt++;
	endtask

	task automatic queue_ticks(int n);
		logic [2:0] fn;
		repeat (n) begin
			fn = ($urandom_range(15) == 0) ? 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI))
				: FN_TICK;
			queue_item(fn, 8'($urandom), 1'($urandom));
		end
	endtask

	task automatic queue_simple(logic [2:0] fn, int halves);
		queue_item(fn, 8'($urandom), 1'($urandom));
		queue_ticks(halves * half_len(sel_speed));
	endtask

	task automatic queue_write(logic [7:0] b, int high_polls, bit lose_ack);
		int d;
		d = half_len(sel_speed);
		queue_item(FN_WRITE, b, 1'($urandom));
		queue_ticks(26 * d - 1);
		if (lose_ack) begin
			repeat (tmo_polls()) queue_item(FN_TICK, 8'($urandom), 1'b1);
			queue_ticks(2 * d);
		end else begin
			repeat (high_polls) queue_item(FN_TICK, 8'($urandom), 1'b1);
			queue_item(FN_TICK, 8'($urandom), 1'b0);
		end
	endtask

	// Mostly complete transactions with random content, some stray items in between.
	task automatic queue_mix(int n);
		int  pick;
		int  hpmax;
		bit  lose;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				queue_item(3'($urandom), 8'($urandom), 1'($urandom));
			end else if (pick < 25) begin
				queue_simple(FN_START, 2);
			end else if (pick < 35) begin
				queue_simple(FN_STOP, 2);
			end else if (pick < 65) begin
				lose = (sel_tmo <= 8) && ($urandom_range(2) == 0);
				hpmax = (tmo_polls() - 1 < 3) ? tmo_polls() - 1 : 3;
				queue_write(8'($urandom), $urandom_range(hpmax), lose);
			end else begin
				queue_simple($urandom_range(1) ? FN_RD_ACK : FN_RD_NACK, 18);
			end
			queue_ticks($urandom_range(2));
		end
	endtask

	task automatic drain_engine();
		while (taken_cnt != pushed_cnt || bus_expect_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_SPEED_SELECT: sel_speed = val[SPEED_W-1:0];
			REG_LSB_FIRST: sel_lsb = val[0];
			REG_ACK_TIMEOUT: sel_tmo = val[TMO_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(int speed, int lsb, int tmo);
		drain_engine();
		write_reg(REG_SPEED_SELECT, CFG_W'(speed));
		write_reg(REG_LSB_FIRST, CFG_W'(lsb));
		write_reg(REG_ACK_TIMEOUT, CFG_W'(tmo));
	endtask

	always @(negedge clk) begin
		if (!in_valid || took) begin
			took = 1'b0;
			if (cmd_q.size() > 0 && (src_calm || $urandom_range(99) >= 27)) begin
				next_cmd = cmd_q.pop_front();
				func <= next_cmd.fn;
				wr_byte <= next_cmd.wr;
				sda_in <= next_cmd.sda;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (sink_hold)
			out_ready <= 1'b0;
		else if (snk_calm)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(99) >= 27);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_view = '{scl: scl_out, sda: sda_out, drv: sda_drive, busy: busy_res,
				done: done_res, st: status_t'(status), rd: rd_byte};
			if (bus_expect_q.size() == 0) begin
				bad_cnt++;
				if (bad_cnt <= 10)
					$display("result item with nothing expected: %s", view_str(seen_view));
			end else begin
				want_view = bus_expect_q.pop_front();
				if (seen_view !== want_view) begin
					bad_cnt++;
					if (bad_cnt <= 10)
						$display("mismatch at %0t\n  expected %s\n  actual   %s", $realtime,
							view_str(want_view), view_str(seen_view));
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			took = 1'b1;
			taken_cnt++;
			bus_expect_q.push_back(engine_step(func, wr_byte, sda_in));
		end
	end

	initial begin
		wait (squeeze_go);
		sink_hold = 1'b1;
		for (int n = 0; n < 60; n++)
			@(posedge clk);
		sink_hold = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("** i2c_master_bit_engine_core: FAILED **");
		$finish;
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Fastest speed and a zero ack timeout, so the first high poll gives up.
		configure(4, 0, 0);
		queue_item(FN_TICK, 8'h00, 1'b0);
		queue_item(FN_SPARE_LO, 8'hFF, 1'b1);
		queue_item(FN_SPARE_HI, 8'h55, 1'b0);
		queue_item(FN_START, 8'h00, 1'b1);
		queue_item(FN_WRITE, 8'hAA, 1'b0);
		queue_item(FN_RD_NACK, 8'h55, 1'b1);
		queue_ticks(2);
		queue_write(8'hFF, 0, 1'b1);
		queue_simple(FN_START, 2);
		queue_write(8'h00, 0, 1'b0);
		queue_simple(FN_RD_ACK, 18);
		queue_simple(FN_RD_NACK, 18);
		queue_item(FN_STOP, 8'hFF, 1'b0);
		queue_item(FN_START, 8'h00, 1'b1);
		queue_item(FN_STOP, 8'h0F, 1'b0);
		queue_ticks(2);
		queue_simple(FN_RD_ACK, 18);
		queue_write(8'h81, 0, 1'b0);
		queue_write(8'h7E, 0, 1'b1);
		queue_simple(FN_STOP, 2);

		configure(3, 1, 1);
		queue_mix(2);

		configure(0, 0, 1);
		queue_simple(FN_START, 2);
		queue_simple(FN_STOP, 2);

		// No idling on either side; the receiver stalls once so the input backs up.
		configure(4, 1, 2);
		src_calm = 1'b1;
		snk_calm = 1'b1;
		queue_mix(6);
		squeeze_go = 1'b1;

		configure(7, 0, 3);
		src_calm = 1'b0;
		snk_calm = 1'b0;
		queue_mix(1);

		configure(2, 1, 1000);
		queue_simple(FN_START, 2);
		queue_simple(FN_RD_ACK, 18);

		configure(1, 0, 65535);
		queue_mix(1);

		configure(5, 1, 4);
		queue_mix(1);

		drain_engine();
		repeat (10) @(posedge clk);
		if (bad_cnt == 0)
			$display("** i2c_master_bit_engine_core: PASSED **");
		else
			$display("** i2c_master_bit_engine_core: FAILED **");
		$finish;
	end

endmodule

// File: sim.f
rtl/i2cbe_pkg.sv
rtl/i2cbe_step.sv
rtl/i2c_master_bit_engine_core.sv
bench/i2c_master_bit_engine_core_tb.sv
